// File: design/i2cmbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbc_pkg
// Types, codes and constants shared by the i2c master byte controller.
// ----------------------------------------------------------------------------
package i2cmbc_pkg;

  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int PHASE_W    = 5;
  localparam int LEN_W      = 10;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LEN_W-1:0] PHASE_LENGTH_RESET = LEN_W'(30);

  // register index carried in paddr[2]
  localparam logic REG_PHASE_LENGTH = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_SCL_HIGH = 3'd5,
    CMD_SCL_LOW  = 3'd6
  } cmd_t;

  // phases within a command
  localparam logic [PHASE_W-1:0] PH_ACK_LOW   = PHASE_W'(16);
  localparam logic [PHASE_W-1:0] PH_ACK_HIGH  = PHASE_W'(17);
  localparam logic [PHASE_W-1:0] PH_LAST_DATA = PHASE_W'(15);

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] write_data;
    logic              send_ack_level;
    logic              sda_sample;
  } item_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_enable;
    logic              busy_flag;
    logic              op_done;
    logic [BYTE_W-1:0] read_data;
    logic              ack_received;
  } result_t;

  typedef struct packed {
    cmd_t               active;
    logic [PHASE_W-1:0] phase;
    logic [LEN_W-1:0]   ticks;
    logic [BYTE_W-1:0]  shift;
    logic               ack_hold;
    logic               ack_seen;
    logic               scl;
    logic               sda;
    logic               sda_en;
    logic [BYTE_W-1:0]  read_hold;
  } state_t;

  localparam state_t STATE_RESET = '{
    active:    CMD_NONE,
    phase:     '0,
    ticks:     '0,
    shift:     '0,
    ack_hold:  1'b0,
    ack_seen:  1'b0,
    scl:       1'b1,
    sda:       1'b1,
    sda_en:    1'b1,
    read_hold: '0
  };

  function automatic logic [PHASE_W-1:0] phase_count(input cmd_t cmd);
    logic [PHASE_W-1:0] n;
    unique case (cmd)
      CMD_START, CMD_STOP: n = PHASE_W'(4);
      CMD_WRITE, CMD_READ: n = PHASE_W'(18);
      default:             n = PHASE_W'(1);
    endcase
    return n;
  endfunction

endpackage

// File: design/i2cmbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbc_if
// Valid/ready channels for bus ticks in and bus levels out.
// ----------------------------------------------------------------------------
interface i2cmbc_in_if
  import i2cmbc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] write_data;
  logic              send_ack_level;
  logic              sda_sample;

  modport source (output valid, command, write_data, send_ack_level, sda_sample,
                  input ready);
  modport sink (input valid, command, write_data, send_ack_level, sda_sample,
                output ready);
endinterface

interface i2cmbc_out_if
  import i2cmbc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_level;
  logic              sda_enable;
  logic              busy_flag;
  logic              op_done;
  logic [BYTE_W-1:0] read_data;
  logic              ack_received;

  modport source (output valid, scl_level, sda_level, sda_enable, busy_flag, op_done,
                  read_data, ack_received, input ready);
  modport sink (input valid, scl_level, sda_level, sda_enable, busy_flag, op_done,
                read_data, ack_received, output ready);
endinterface

// File: design/i2cmbc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbc_cfg
// APB register file holding the bus phase length.
// ----------------------------------------------------------------------------
module i2cmbc_cfg
  import i2cmbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [LEN_W-1:0]      phase_length
);

  logic wr_phase_length;

  assign pready          = 1'b1;
  assign wr_phase_length = psel && penable && pwrite && (paddr[2] == REG_PHASE_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_length <= PHASE_LENGTH_RESET;
    end else if (wr_phase_length) begin
      phase_length <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PHASE_LENGTH) begin
      prdata = APB_DATA_W'(phase_length);
    end
  end

endmodule

// File: design/i2cmbc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbc_step
// One bus tick: command pickup, phase drive, SDA sampling and phase advance.
// ----------------------------------------------------------------------------
module i2cmbc_step
  import i2cmbc_pkg::*;
(
  input  state_t           cur,
  input  item_t            item,
  input  logic [LEN_W-1:0] phase_length,
  output state_t           nxt,
  output result_t          res
);

  state_t             s;
  logic [LEN_W-1:0]   len;
  logic [LEN_W:0]     ticks_inc;
  logic [PHASE_W-1:0] p;
  logic [PHASE_W-1:0] phase_inc;
  logic               busy;
  logic               done;
  logic [BYTE_W-1:0]  shifted;

  assign len = (phase_length == '0) ? LEN_W'(1) : phase_length;

  always_comb begin
    s         = cur;
    done      = 1'b0;
    ticks_inc = '0;
    phase_inc = '0;
    shifted   = '0;
    p         = '0;

    if (s.active == CMD_NONE && item.command >= CMD_START && item.command <= CMD_SCL_LOW) begin
      s.active = cmd_t'(item.command);
      s.phase  = '0;
      s.ticks  = '0;
      if (item.command == CMD_WRITE) begin
        s.shift = item.write_data;
      end
      if (item.command == CMD_READ) begin
        s.shift    = '0;
        s.ack_hold = item.send_ack_level;
      end
    end

    busy = (s.active != CMD_NONE);

    if (busy) begin
      p = s.phase;
      // bus levels for the current phase
      unique case (s.active)
        CMD_START: begin
          priority case (p)
            PHASE_W'(0): begin s.sda_en = 1'b1; s.sda = 1'b1; end
            PHASE_W'(1): s.scl = 1'b1;
            PHASE_W'(2): begin s.sda_en = 1'b1; s.sda = 1'b0; end
            default:     s.scl = 1'b0;
          endcase
        end
        CMD_STOP: begin
          priority case (p)
            PHASE_W'(0): s.scl = 1'b0;
            PHASE_W'(1): begin s.sda_en = 1'b1; s.sda = 1'b0; end
            PHASE_W'(2): s.scl = 1'b1;
            default:     begin s.sda_en = 1'b1; s.sda = 1'b1; end
          endcase
        end
        CMD_WRITE, CMD_READ: begin
          if (p[0]) begin
            s.scl = 1'b1;
          end else begin
            s.scl = 1'b0;
            // master owns sda for write data and for the read acknowledge
            if ((p < PH_ACK_LOW) == (s.active == CMD_WRITE)) begin
              s.sda_en = 1'b1;
              s.sda    = (p < PH_ACK_LOW) ? s.shift[3'd7 - p[3:1]] : s.ack_hold;
            end else begin
              s.sda_en = 1'b0;
              s.sda    = 1'b1;
            end
          end
        end
        CMD_SCL_HIGH: s.scl = 1'b1;
        default:      s.scl = 1'b0;
      endcase

      ticks_inc = {1'b0, s.ticks} + (LEN_W+1)'(1);
      if (ticks_inc >= {1'b0, len}) begin
        if (s.active == CMD_WRITE && p == PH_ACK_HIGH) begin
          s.ack_seen = item.sda_sample;
        end else if (s.active == CMD_READ && p < PH_ACK_LOW && p[0]) begin
          shifted = {s.shift[BYTE_W-2:0], item.sda_sample};
          s.shift = shifted;
          if (p == PH_LAST_DATA) begin
            s.read_hold = shifted;
          end
        end
        s.ticks   = '0;
        phase_inc = p + PHASE_W'(1);
        s.phase   = phase_inc;
        if (phase_inc >= phase_count(s.active)) begin
          s.active = CMD_NONE;
          s.phase  = '0;
          done     = 1'b1;
        end
      end else begin
        s.ticks = ticks_inc[LEN_W-1:0];
      end
    end

    nxt = s;
    res = '{
      scl_level:    s.scl,
      sda_level:    s.sda,
      sda_enable:   s.sda_en,
      busy_flag:    busy,
      op_done:      done,
      read_data:    s.read_hold,
      ack_received: s.ack_seen
    };
  end

endmodule

// File: design/i2c_master_byte_controller_top.sv
`timescale 1ns / 1ps
// ticks pass the input register, then the result register; one state step per tick
// throughput: one tick per cycle unless the result channel stalls, one result per tick
// backpressure on the result channel stalls the input register, nothing is dropped
// reset (synchronous, rst high): bus free with scl and sda high and driven, no command,
// phase length 30, read_data and ack_received zero
// ----------------------------------------------------------------------------
// i2c_master_byte_controller_top
// Tick-driven i2c master byte sequencer with an APB phase length register.
// ----------------------------------------------------------------------------
module i2c_master_byte_controller_top
  import i2cmbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  i2cmbc_in_if.sink             in_ch,
  i2cmbc_out_if.source          out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic             in_vld;
  item_t            in_item;
  logic             out_vld;
  result_t          out_res;
  state_t           state;
  state_t           state_next;
  result_t          res_next;
  logic [LEN_W-1:0] phase_length;
  logic             advance;

  i2cmbc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .phase_length (phase_length)
  );

  i2cmbc_step u_step (
    .cur          (state),
    .item         (in_item),
    .phase_length (phase_length),
    .nxt          (state_next),
    .res          (res_next)
  );

  // result register free or being emptied this cycle
  assign advance     = !out_vld || out_ch.ready;
  assign in_ch.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item <= '{
        command:        in_ch.command,
        write_data:     in_ch.write_data,
        send_ack_level: in_ch.send_ack_level,
        sda_sample:     in_ch.sda_sample
      };
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= STATE_RESET;
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
      if (in_vld) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld) begin
      out_res <= res_next;
    end
  end

  assign out_ch.valid        = out_vld;
  assign out_ch.scl_level    = out_res.scl_level;
  assign out_ch.sda_level    = out_res.sda_level;
  assign out_ch.sda_enable   = out_res.sda_enable;
  assign out_ch.busy_flag    = out_res.busy_flag;
  assign out_ch.op_done      = out_res.op_done;
  assign out_ch.read_data    = out_res.read_data;
  assign out_ch.ack_received = out_res.ack_received;

endmodule

// File: design/i2cmbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbc_checker
// Port-level checks for the i2c master byte controller, bound to the top.
// ----------------------------------------------------------------------------
module i2cmbc_checker
  import i2cmbc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_busy,
  input logic                  out_done,
  input logic                  out_scl,
  input logic                  out_sda,
  input logic                  out_sda_en,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready
);

  // a finishing tick is always a busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_done || out_busy))
    else $error("op_done without busy_flag");

  // a stalled result keeps waiting
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // nothing in flight means a free input side
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |=> (in_ready || $past(in_valid)))
    else $error("input stalled with empty pipeline");

  // released sda always reads back as high level
  a_sda_release: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_sda_en) |-> (out_sda && (out_busy || !out_scl || out_scl)))
    else $error("released sda not high");

  a_apb: assert property (@(posedge clk) disable iff (rst)
    pready && (prdata[APB_DATA_W-1:LEN_W] == '0))
    else $error("apb ready or read data upper bits wrong");

endmodule

bind i2c_master_byte_controller_top i2cmbc_checker u_i2cmbc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_busy   (out_ch.busy_flag),
  .out_done   (out_ch.op_done),
  .out_scl    (out_ch.scl_level),
  .out_sda    (out_ch.sda_level),
  .out_sda_en (out_ch.sda_enable),
  .prdata     (prdata),
  .pready     (pready)
);
